// ===== design/tcc_pkg.sv =====
// Shared constants, types and helpers of the text console engine.
package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;

    // Character and color codes
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE  = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE    = 8'd32;
    localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'd15;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_PUT
    } t_state;

    // What a fill pass finishes
    typedef enum logic [1:0] {
        JOB_BOOT,
        JOB_CLEAR,
        JOB_NEWLINE,
        JOB_WRAP_PUT
    } t_job;

    // One character cell of the screen store
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CHAR_W-1:0]  ch;
    } t_cell;

    // Write port request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_cell             data;
    } t_mem_wr;

    // Finished result from the sequencer
    typedef struct packed {
        logic               valid;
        logic [CHAR_W-1:0]  cell_char;
        logic [COLOR_W-1:0] cell_color;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } t_result;

    // Linear address of a cell, row-major
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

// ===== design/tcc_screen_ram.sv =====
// Screen cell store: one write port, one read port with registered read data.
module tcc_screen_ram (
    input  logic                  i_clk,
    input  tcc_pkg::t_mem_wr      i_wr,
    input  logic [tcc_pkg::ADDR_W-1:0] i_rd_addr,
    output tcc_pkg::t_cell        o_rd_data
);
    import tcc_pkg::*;

    t_cell r_mem [CELLS];
    t_cell r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tcc_seq.sv =====
// Command sequencer: cursor, cell writes, scroll copy and fill sweeps.
module tcc_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tcc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcc_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tcc_pkg::COL_W-1:0]   i_read_col,
    input  logic [tcc_pkg::COLOR_W-1:0] i_text_color,
    input  logic                        i_out_free,
    output tcc_pkg::t_mem_wr            o_wr,
    output logic [tcc_pkg::ADDR_W-1:0]  o_rd_addr,
    input  tcc_pkg::t_cell              i_rd_data,
    output tcc_pkg::t_result            o_res
);
    import tcc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY   = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

    t_state             r_state, n_state;
    t_job               r_job, n_job;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [COLOR_W-1:0] r_fill_color, n_fill_color;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_cp_valid, n_cp_valid;
    logic [ADDR_W-1:0]  r_cp_addr, n_cp_addr;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;

    logic               accept;
    logic               wrap;
    logic               last_row;
    logic               rd_in_range;
    logic [ROW_W-1:0]   eff_row;
    logic [COL_W-1:0]   eff_col;

    // Cursor conditions
    assign wrap        = (r_col >= COL_W'(COLUMNS));
    assign last_row    = (r_row == ROW_W'(ROWS - 1));
    assign eff_row     = wrap ? r_row + ROW_W'(1) : r_row;
    assign eff_col     = wrap ? '0 : r_col;
    assign rd_in_range = (int'(i_read_row) < ROWS) && (int'(i_read_col) < COLUMNS);

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign accept     = i_in_valid && o_in_ready;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_job        <= JOB_BOOT;
            r_addr       <= '0;
            r_fill_color <= DEFAULT_COLOR;
            r_cp_valid   <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
        end else begin
            r_state      <= n_state;
            r_job        <= n_job;
            r_addr       <= n_addr;
            r_fill_color <= n_fill_color;
            r_cp_valid   <= n_cp_valid;
            r_row        <= n_row;
            r_col        <= n_col;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_cp_addr <= n_cp_addr;
    end

    // Next state, memory requests and result
    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_addr       = r_addr;
        n_fill_color = r_fill_color;
        n_char       = r_char;
        n_cp_valid   = 1'b0;
        n_cp_addr    = r_cp_addr;
        n_row        = r_row;
        n_col        = r_col;
        o_wr         = '0;
        o_rd_addr    = r_addr + ROW_STRIDE;
        o_res        = '0;

        unique case (r_state)
            S_IDLE: begin
                o_rd_addr = cell_addr(i_read_row, i_read_col);
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_PUT: begin
                            n_fill_color = i_text_color;
                            if (i_char_code == NEWLINE_CODE) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_state = S_SCROLL;
                                    n_addr  = '0;
                                    n_job   = JOB_NEWLINE;
                                end else begin
                                    n_row       = r_row + ROW_W'(1);
                                    o_res.valid = 1'b1;
                                end
                            end else if (wrap && last_row) begin
                                // full bottom row: scroll, blank, then put at column 0
                                n_col   = COL_W'(1);
                                n_char  = i_char_code;
                                n_state = S_SCROLL;
                                n_addr  = '0;
                                n_job   = JOB_WRAP_PUT;
                            end else begin
                                o_wr.en     = 1'b1;
                                o_wr.addr   = cell_addr(eff_row, eff_col);
                                o_wr.data   = '{color: i_text_color, ch: i_char_code};
                                n_row       = eff_row;
                                n_col       = eff_col + COL_W'(1);
                                o_res.valid = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill_color = i_text_color;
                            n_state      = S_FILL;
                            n_addr       = '0;
                            n_job        = JOB_CLEAR;
                        end
                        CMD_READ: begin
                            if (rd_in_range) begin
                                n_state = S_READ;
                            end else begin
                                o_res.valid = 1'b1;
                            end
                        end
                        CMD_NOP: begin
                            o_res.valid = 1'b1;
                        end
                    endcase
                end
            end

            // registered read data arrives in the cycle after the address
            S_READ: begin
                o_res.valid      = 1'b1;
                o_res.cell_char  = i_rd_data.ch;
                o_res.cell_color = i_rd_data.color;
                n_state          = S_IDLE;
            end

            // copy cell k+COLUMNS to k; the write comes in the cycle after the read
            S_SCROLL: begin
                if (r_cp_valid) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_cp_addr;
                    o_wr.data = i_rd_data;
                end
                n_cp_valid = 1'b1;
                n_cp_addr  = r_addr;
                if (r_addr == LAST_COPY) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end

            // last copy write, then blank the bottom row
            S_DRAIN: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_cp_addr;
                o_wr.data = i_rd_data;
                n_state   = S_FILL;
                n_addr    = BOTTOM_BASE;
            end

            // write spaces from r_addr up to the last cell
            S_FILL: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_addr;
                o_wr.data = '{color: r_fill_color, ch: SPACE_CODE};
                if (r_addr == LAST_CELL) begin
                    unique case (r_job)
                        JOB_BOOT:     n_state = S_IDLE;
                        JOB_WRAP_PUT: n_state = S_PUT;
                        JOB_CLEAR,
                        JOB_NEWLINE: begin
                            n_state     = S_IDLE;
                            o_res.valid = 1'b1;
                        end
                    endcase
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end

            // character held over a scroll lands at the start of the bottom row
            S_PUT: begin
                o_wr.en     = 1'b1;
                o_wr.addr   = BOTTOM_BASE;
                o_wr.data   = '{color: r_fill_color, ch: r_char};
                o_res.valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.row = n_row;
        o_res.col = n_col;
    end

endmodule

// ===== design/text_console_cursor_scroll.sv =====
// Text console engine top level: color register, sequencer, cell store, result register.
//
// An 80x25 text console whose cells live in one single-port-write memory with a registered
// read. A put or newline that does not scroll, a no-op and an out-of-range read finish in the
// cycle they are accepted; an in-range read finishes in S_READ once the registered read data
// is back. Every memory write goes through the one write port, one cell per cycle, so the long
// commands are sweeps: a clear writes all 2000 cells, a scroll (newline or wrapped put on the
// bottom row) copies 1920 cells up a row, makes the last copy write in S_DRAIN and blanks the
// 80 bottom-row cells, and a wrapped put then writes its character. Items are taken one at a
// time. After reset a clearing pass fills all 2000 cells with spaces in color 15 before the
// block accepts its first item; color register writes are taken throughout.
module text_console_cursor_scroll (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_text_color_we,
    input  logic [tcc_pkg::COLOR_W-1:0] i_text_color,
    // command channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tcc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcc_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tcc_pkg::COL_W-1:0]   i_read_col,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tcc_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcc_pkg::COLOR_W-1:0] o_cell_color,
    output logic [tcc_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcc_pkg::COL_W-1:0]   o_cursor_col
);
    import tcc_pkg::*;

    logic [COLOR_W-1:0] r_color;
    logic               r_out_valid;
    t_result            r_out;
    t_result            res;
    t_mem_wr            wr;
    logic [ADDR_W-1:0]  rd_addr;
    t_cell              rd_data;
    logic               out_free;

    // Color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= DEFAULT_COLOR;
        end else if (i_text_color_we) begin
            r_color <= i_text_color;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    tcc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_text_color (r_color),
        .i_out_free   (out_free),
        .o_wr         (wr),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_res        (res)
    );

    tcc_screen_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out.cell_char;
    assign o_cell_color = r_out.cell_color;
    assign o_cursor_row = r_out.row;
    assign o_cursor_col = r_out.col;

endmodule
